FILE: sv/servo_pulse_generator_unit_macros.svh
// Assertion macros for the servo pulse generator checker.
`ifndef SERVO_PULSE_GENERATOR_UNIT_MACROS_SVH
`define SERVO_PULSE_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("servo pulse generator check failed");

// Next-cycle implication, disabled during reset.
`define SPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("servo pulse generator check failed");

// Condition that holds in the cycle after reset is applied.
`define SPG_ASSERT_RST(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("servo pulse generator reset check failed");

`endif

FILE: sv/spg_pkg.sv
package spg_pkg;

  localparam int CHANNELS   = 2;
  localparam int MAX_CH     = 8;
  localparam int FUNC_W     = 2;
  localparam int CH_W       = 3;
  localparam int VAL_W      = 16;
  localparam int W_W        = 19;
  localparam int CNT_W      = 28;
  localparam int FP_W       = 24;
  localparam int SS_W       = 20;
  localparam int TRIM_W     = 14;
  localparam int GAIN_W     = 18;
  localparam int FRAME_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int QDEPTH     = 2;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RAW  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_HRAW = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_POS  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STAGGER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd7;

  localparam logic [1:0] MODE_PULSE = 2'd0;
  localparam logic [1:0] MODE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic signed [16:0] RAW_CENTER = 17'sd1024;
  localparam logic signed [24:0] RAW_STEP   = 25'sd60;
  localparam logic signed [22:0] ONE_Q14    = 23'sd16384;
  localparam int                 Q14_SH     = 14;

  // floor(n * 16384 / 500) for n below 2^16 as (n * RECIP) >> RECIP_SH
  localparam int                 RECIP_W    = 29;
  localparam logic [RECIP_W-1:0] HRAW_RECIP = 29'd274877907;
  localparam int                 RECIP_SH   = 23;
  localparam int                 HQ_W       = 21;

  localparam logic [W_W-1:0] RST_CENTER = 19'd187500;

  typedef struct packed {
    logic [W_W-1:0]           min_width;
    logic [W_W-1:0]           center_width;
    logic [W_W-1:0]           max_width;
    logic [FP_W-1:0]          frame_period;
    logic [CNT_W-1:0]         start_delay;
    logic [SS_W-1:0]          start_stagger;
    logic [TRIM_W-1:0]        trim_offset;
    logic [GAIN_W-1:0]        pos_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_width:     19'd112500,
    center_width:  19'd187500,
    max_width:     19'd262400,
    frame_period:  24'd2500000,
    start_delay:   28'd250000000,
    start_stagger: 20'd524800,
    trim_offset:   14'd737,
    pos_gain:      18'd74950
  };

  typedef struct packed {
    logic            valid;
    logic            wr;
    logic [CH_W-1:0] ch;
    logic [W_W-1:0]  width;
  } cmd_t;

endpackage

FILE: sv/spg_front.sv
module spg_front import spg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic [CH_W-1:0]         in_command_channel,
  input  logic signed [VAL_W-1:0] in_command_value,
  input  cfg_t                    cfg,
  output logic                    q_push,
  output cmd_t                    q_data,
  input  logic                    q_full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DIV  = 3'd1;
  localparam logic [2:0] F_POS  = 3'd2;
  localparam logic [2:0] F_GAIN = 3'd3;
  localparam logic [2:0] F_FIN  = 3'd4;

  localparam int P1_W = VAL_W + RECIP_W;
  localparam int P2_W = 34;
  localparam int T_W  = 36;

  logic [2:0]              state_r, state_nxt;
  logic [FUNC_W-1:0]       func_r;
  logic [CH_W-1:0]         ch_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    valid_r;
  logic                    dneg_r;
  logic [VAL_W-1:0]        dabs_r;
  logic [P1_W-1:0]         prod1_r;
  logic                    lo_r, hi_r;
  logic signed [14:0]      pm_r;
  logic [W_W-1:0]          wraw_r;
  logic signed [P2_W-1:0]  prod2_r;

  logic signed [16:0]      din_d;
  logic [HQ_W-1:0]         q_mag;
  logic signed [21:0]      hp;
  logic signed [22:0]      psel, ptrim, pval;
  logic signed [16:0]      rd;
  logic signed [24:0]      rw;
  logic [W_W-1:0]          wraw;
  logic signed [P2_W-1:0]  pm_ext, gain_ext;
  logic signed [T_W-1:0]   tsum;
  logic [W_W-1:0]          wpos, wfin;
  logic                    accept;

  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && !in_full;

  always_comb begin
    din_d = 17'(in_command_value) - RAW_CENTER;

    q_mag = prod1_r[RECIP_SH +: HQ_W];
    hp    = dneg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    psel  = (func_r == FUNC_HRAW) ? 23'(hp) : 23'(val_r);
    ptrim = (ch_r == '0) ? 23'($signed(cfg.trim_offset)) : '0;
    pval  = psel + ptrim;

    rd = 17'(val_r) - RAW_CENTER;
    rw = 25'(rd) * RAW_STEP + $signed({6'd0, cfg.center_width});
    if (rw <= $signed({6'd0, cfg.min_width})) begin
      wraw = cfg.min_width;
    end else if (rw >= $signed({6'd0, cfg.max_width})) begin
      wraw = cfg.max_width;
    end else begin
      wraw = rw[W_W-1:0];
    end

    pm_ext   = P2_W'(pm_r);
    gain_ext = $signed({16'd0, cfg.pos_gain});

    tsum = $signed({3'd0, cfg.center_width, 14'd0}) + T_W'(prod2_r);
    if (tsum[T_W-1]) begin
      wpos = '0;
    end else if (|tsum[T_W-2:W_W+Q14_SH]) begin
      wpos = '1;
    end else begin
      wpos = tsum[W_W+Q14_SH-1:Q14_SH];
    end

    if (func_r == FUNC_RAW) begin
      wfin = wraw_r;
    end else if (lo_r) begin
      wfin = cfg.min_width;
    end else if (hi_r) begin
      wfin = cfg.max_width;
    end else begin
      wfin = wpos;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (accept) state_nxt = F_DIV;
      F_DIV:  state_nxt = F_POS;
      F_POS:  state_nxt = F_GAIN;
      F_GAIN: state_nxt = F_FIN;
      F_FIN:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      ch_r    <= in_command_channel;
      val_r   <= in_command_value;
      valid_r <= ({1'b0, in_command_channel} < 4'(CHANNELS));
      dneg_r  <= din_d[16];
      dabs_r  <= din_d[16] ? VAL_W'(-din_d) : VAL_W'(din_d);
    end
    if (state_r == F_DIV) begin
      prod1_r <= {{RECIP_W{1'b0}}, dabs_r} * {{VAL_W{1'b0}}, HRAW_RECIP};
    end
    if (state_r == F_POS) begin
      lo_r   <= (pval <= -ONE_Q14);
      hi_r   <= (pval >= ONE_Q14);
      pm_r   <= pval[14:0];
      wraw_r <= wraw;
    end
    if (state_r == F_GAIN) begin
      prod2_r <= pm_ext * gain_ext;
    end
  end

  assign q_push       = (state_r == F_FIN) && !q_full;
  assign q_data.valid = valid_r;
  assign q_data.wr    = valid_r && (func_r != FUNC_TICK);
  assign q_data.ch    = ch_r;
  assign q_data.width = wfin;

endmodule

FILE: sv/spg_fifo.sv
module spg_fifo import spg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W_Q = $clog2(QDEPTH + 1);

  cmd_t               mem_r [QDEPTH];
  logic [PTR_W-1:0]   wptr_r, rptr_r;
  logic [CNT_W_Q-1:0] count_r;
  logic               do_push, do_pop;

  assign full     = (count_r == CNT_W_Q'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/spg_back.sv
module spg_back import spg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  cmd_t               q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [MAX_CH-1:0]  out_pulse_levels,
  output logic               out_frame_strobe,
  output logic [FRAME_W-1:0] out_frame_count,
  output logic [W_W-1:0]     out_channel_width
);

  logic [CNT_W-1:0] cnt_r  [CHANNELS];
  logic [CNT_W-1:0] ref_r  [CHANNELS];
  logic [1:0]       mode_r [CHANNELS];
  logic [W_W-1:0]   elap_r [CHANNELS];
  logic [W_W-1:0]   cmdw_r [CHANNELS];
  logic [CNT_W-1:0] cnt_nxt  [CHANNELS];
  logic [CNT_W-1:0] ref_nxt  [CHANNELS];
  logic [1:0]       mode_nxt [CHANNELS];
  logic [W_W-1:0]   elap_nxt [CHANNELS];
  logic [W_W-1:0]   cmdw_nxt [CHANNELS];
  logic [CHANNELS-1:0] lvl_r, lvl_nxt;
  logic [FRAME_W-1:0]  frames_r, frames_nxt;

  logic                ovalid_r;
  logic [MAX_CH-1:0]   olev_r, olev_nxt;
  logic                ostb_r, ostb_nxt;
  logic [W_W-1:0]      owid_r, owid_nxt;

  logic [CNT_W-1:0]    ref_eff;
  logic                go;

  assign go    = !q_empty && (!ovalid_r || out_pop);
  assign q_pop = go;

  always_comb begin
    frames_nxt = frames_r;
    ostb_nxt   = 1'b0;
    olev_nxt   = '0;
    owid_nxt   = '0;
    lvl_nxt    = lvl_r;
    ref_eff    = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      cmdw_nxt[i] = (q_data.wr && (q_data.ch == CH_W'(i))) ? q_data.width : cmdw_r[i];
      ref_eff = (mode_r[i] == MODE_START)
              ? cfg.start_delay + CNT_W'(i) * CNT_W'(cfg.start_stagger)
              : ref_r[i];
      mode_nxt[i] = mode_r[i];
      elap_nxt[i] = elap_r[i];
      ref_nxt[i]  = ref_eff;
      if (cnt_r[i] == ref_eff) begin
        cnt_nxt[i] = CNT_W'(1);
        lvl_nxt[i] = !lvl_r[i];
        if (mode_r[i] == MODE_WAIT) begin
          elap_nxt[i] = cmdw_nxt[i];
          ref_nxt[i]  = CNT_W'(cmdw_nxt[i]);
          mode_nxt[i] = MODE_PULSE;
        end else begin
          ref_nxt[i]  = CNT_W'(cfg.frame_period) - CNT_W'(elap_r[i]);
          mode_nxt[i] = MODE_WAIT;
          if (i == 0) begin
            ostb_nxt   = 1'b1;
            frames_nxt = frames_r + 1'b1;
          end
        end
      end else begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end
      olev_nxt[i] = lvl_nxt[i];
      if (q_data.valid && (q_data.ch == CH_W'(i))) begin
        owid_nxt = cmdw_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i]  <= CNT_W'(1);
        ref_r[i]  <= '0;
        mode_r[i] <= MODE_START;
        elap_r[i] <= '0;
        cmdw_r[i] <= RST_CENTER;
      end
      lvl_r    <= '0;
      frames_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (go) begin
        cnt_r    <= cnt_nxt;
        ref_r    <= ref_nxt;
        mode_r   <= mode_nxt;
        elap_r   <= elap_nxt;
        cmdw_r   <= cmdw_nxt;
        lvl_r    <= lvl_nxt;
        frames_r <= frames_nxt;
        ovalid_r <= 1'b1;
      end else if (out_pop) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      olev_r <= olev_nxt;
      ostb_r <= ostb_nxt;
      owid_r <= owid_nxt;
    end
  end

  assign out_empty         = !ovalid_r;
  assign out_pulse_levels  = olev_r;
  assign out_frame_strobe  = ostb_r;
  assign out_frame_count   = frames_r;
  assign out_channel_width = owid_r;

endmodule

FILE: sv/servo_pulse_generator_unit.sv
// Channel   Handshake              Payload
// in_       in_push / in_full      in_func, in_command_channel, in_command_value
// out_      out_pop / out_empty    out_pulse_levels, out_frame_strobe,
//                                  out_frame_count, out_channel_width
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item passes five steps in the front width sequencer (accept, reciprocal
// product for the high-raw divide, position clamp, gain product, final clamp);
// the back part then registers the timer update; no new item enters until idle.
// Reset is synchronous: registers return to defaults, all channels enter start
// mode, both queues empty. A full command queue holds the front in its last
// step; a result not popped holds the back, which then stops draining the queue.
module servo_pulse_generator_unit import spg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic [CH_W-1:0]         in_command_channel,
  input  logic signed [VAL_W-1:0] in_command_value,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [MAX_CH-1:0]       out_pulse_levels,
  output logic                    out_frame_strobe,
  output logic [FRAME_W-1:0]      out_frame_count,
  output logic [W_W-1:0]          out_channel_width,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN:     cfg_r.min_width     <= cfg_data[W_W-1:0];
        REG_CENTER:  cfg_r.center_width  <= cfg_data[W_W-1:0];
        REG_MAX:     cfg_r.max_width     <= cfg_data[W_W-1:0];
        REG_FRAME:   cfg_r.frame_period  <= cfg_data[FP_W-1:0];
        REG_DELAY:   cfg_r.start_delay   <= cfg_data[CNT_W-1:0];
        REG_STAGGER: cfg_r.start_stagger <= cfg_data[SS_W-1:0];
        REG_TRIM:    cfg_r.trim_offset   <= cfg_data[TRIM_W-1:0];
        REG_GAIN:    cfg_r.pos_gain      <= cfg_data[GAIN_W-1:0];
        default:     cfg_r <= cfg_r;
      endcase
    end
  end

  spg_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_command_channel (in_command_channel),
    .in_command_value   (in_command_value),
    .cfg                (cfg_r),
    .q_push             (q_push),
    .q_data             (q_wdata),
    .q_full             (q_full)
  );

  spg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  spg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_pulse_levels  (out_pulse_levels),
    .out_frame_strobe  (out_frame_strobe),
    .out_frame_count   (out_frame_count),
    .out_channel_width (out_channel_width)
  );

endmodule

FILE: sv/spg_checker.sv
`include "servo_pulse_generator_unit_macros.svh"

module spg_checker import spg_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic [MAX_CH-1:0]  out_pulse_levels,
  input logic               out_frame_strobe,
  input logic [FRAME_W-1:0] out_frame_count
);

  logic [FRAME_W-1:0] last_r;
  logic               seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      last_r <= '0;
    end else if (out_pop && !out_empty) begin
      seen_r <= 1'b1;
      last_r <= out_frame_count;
    end
  end

  `SPG_ASSERT_RST(a_reset_idle, clk, rst_n, out_empty && !in_full)
  `SPG_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_push && !in_full, in_full)
  `SPG_ASSERT_NXT(a_result_holds, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_frame_count) && $stable(out_pulse_levels))
  `SPG_ASSERT_IMP(a_frame_step, clk, rst_n, !out_empty && seen_r, out_frame_count == last_r + FRAME_W'(out_frame_strobe))

endmodule

bind servo_pulse_generator_unit spg_checker u_spg_checker (.*);
